// ===== rtl/assert_macros.svh =====
// assertion macros used by colored_soft_knee_compressor_gain.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("delayed check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_DELAY(label, clk, rst, ante, n, cons)
`endif
`endif

// ===== rtl/cskc_pkg.sv =====
// constants, register codes and coefficient functions of the compressor gain block
// no dependencies
`default_nettype none
package cskc_pkg;
   localparam logic [32:0] K_DB        = 33'd3232284966;
   localparam logic [28:0] K_EXP10     = 29'd356689313;
   localparam logic [30:0] K_LOG2E     = 31'd1549082005;
   localparam logic [30:0] ONE_Q30     = 31'h40000000;
   localparam logic [23:0] GAIN_ONE    = 24'h100000;
   localparam logic [23:0] GAIN_MAX    = 24'h7fffff;
   localparam logic [23:0] GAIN_MIN    = 24'h800000;
   localparam logic [15:0] RATIO_UNITY = 16'd256;
   localparam int          CSR_IW      = 8;
   localparam int          CSR_DW      = 24;

   typedef enum logic [CSR_IW-1:0] {
      CSR_RATIO    = 8'd0,
      CSR_SOFTNESS = 8'd1,
      CSR_COLOR    = 8'd2,
      CSR_QUALITY  = 8'd3
   } csr_index_type;

   function automatic logic [31:0] isqrt64(input logic [63:0] x);
      logic [65:0] rem;
      logic [65:0] trial;
      logic [31:0] root;
      rem  = '0;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         rem   = {rem[63:0], x[2*i+1 -: 2]};
         trial = {32'b0, root, 2'b01};
         if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[30:0], 1'b1};
         end else begin
            root = {root[30:0], 1'b0};
         end
      end
      return root;
   endfunction

   // 2^(-2^-k) in q30
   function automatic logic [29:0] pow2_coef(input int k);
      logic [63:0] c;
      c = 64'(isqrt64(64'd1 << 59));
      for (int j = 2; j <= k; j++) begin
         c = 64'(isqrt64(c << 30));
      end
      return c[29:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/colored_soft_knee_compressor_gain.sv =====
// soft-knee compressor gain computer with colour bump, fully pipelined
// depends on cskc_pkg, cskc_pow2neg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
// One level enters per cycle whenever start is high; busy is always low. Each gain
// appears on rsp_gain with rsp_valid high for one cycle once its level has passed the
// stage chain, which includes one log2 squaring stage per fraction bit, one square-root
// stage per root bit, one division stage per quotient bit and one exponent stage per
// fraction bit. The receiver cannot stall the pipeline. Registers must be written
// only while no level is in flight; the block itself does not enforce this.
module colored_soft_knee_compressor_gain #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [31:0]                  req_level,
   output logic                         rsp_valid,
   output logic signed [23:0]           rsp_gain,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [cskc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [cskc_pkg::CSR_DW-1:0]  csr_data
);
   import cskc_pkg::*;

   localparam int VW  = FRAC_BITS + 7;
   localparam int LW  = FRAC_BITS + 6;
   localparam int D2W = FRAC_BITS + 12;
   localparam int SW  = FRAC_BITS + 17;
   localparam int RB  = FRAC_BITS + 9;
   localparam int XW  = 2 * RB;
   localparam int RW  = RB + 3;
   localparam int EB  = FRAC_BITS + 10;
   localparam int NW  = FRAC_BITS + 26;
   localparam int PL  = FRAC_BITS + 2;
   localparam int LAT = 4 * FRAC_BITS + 29;

   // configuration
   logic [15:0]        ratio_ff;
   logic [23:0]        softness_ff;
   logic signed [15:0] color_ff;
   logic [23:0]        quality_ff;
   logic [15:0]        ratio_eff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff    <= RATIO_UNITY;
         softness_ff <= '0;
         color_ff    <= '0;
         quality_ff  <= 24'd65536;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_RATIO:    ratio_ff    <= csr_data[15:0];
            CSR_SOFTNESS: softness_ff <= csr_data;
            CSR_COLOR:    color_ff    <= $signed(csr_data[15:0]);
            CSR_QUALITY:  quality_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign ratio_eff = (ratio_ff < RATIO_UNITY) ? RATIO_UNITY : ratio_ff;

   // log2: normalize, then one squaring per fraction bit
   logic [4:0]  msb_c;
   logic [62:0] norm_c;

   always_comb begin
      msb_c = '0;
      for (int b = 0; b < 32; b++) begin
         if (req_level[b]) msb_c = 5'(b);
      end
   end

   assign norm_c = {31'b0, req_level} << (5'd31 - msb_c);

   logic                 lg_valid_ff [0:FRAC_BITS];
   logic                 lg_zero_ff  [0:FRAC_BITS];
   logic [4:0]           lg_msb_ff   [0:FRAC_BITS];
   logic [30:0]          lg_m_ff     [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] lg_frac_ff  [0:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) lg_valid_ff[0] <= 1'b0;
      else       lg_valid_ff[0] <= start && !busy;
   end

   always_ff @(posedge clock) begin
      lg_zero_ff[0] <= (req_level == 32'd0);
      lg_msb_ff[0]  <= msb_c;
      lg_m_ff[0]    <= norm_c[31:1];
      lg_frac_ff[0] <= '0;
   end

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_log
      logic [61:0] sq;
      logic [31:0] mm;
      assign sq = 62'(lg_m_ff[k-1]) * 62'(lg_m_ff[k-1]);
      assign mm = sq[61:30];
      always_ff @(posedge clock) begin
         if (reset) lg_valid_ff[k] <= 1'b0;
         else       lg_valid_ff[k] <= lg_valid_ff[k-1];
      end
      always_ff @(posedge clock) begin
         lg_zero_ff[k] <= lg_zero_ff[k-1];
         lg_msb_ff[k]  <= lg_msb_ff[k-1];
         lg_m_ff[k]    <= mm[31] ? mm[31:1] : mm[30:0];
         lg_frac_ff[k] <= {lg_frac_ff[k-1][FRAC_BITS-2:0], mm[31]};
      end
   end

   // decibels
   logic signed [LW-1:0] l2_c;
   logic signed [LW+32:0] db_prod_c;
   logic                 db_valid_ff, db_zero_ff;
   logic signed [VW-1:0] db_d_ff;

   assign l2_c      = $signed({6'({1'b0, lg_msb_ff[FRAC_BITS]}) - 6'd16,
                               lg_frac_ff[FRAC_BITS]});
   assign db_prod_c = l2_c * $signed(K_DB);

   always_ff @(posedge clock) begin
      if (reset) db_valid_ff <= 1'b0;
      else       db_valid_ff <= lg_valid_ff[FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      db_zero_ff <= lg_zero_ff[FRAC_BITS];
      db_d_ff    <= db_prod_c[30 +: VW];
   end

   // squared level
   logic [VW-1:0]        ad_c;
   logic [2*LW-1:0]      adsq_c;
   logic                 sqd_valid_ff, sqd_zero_ff;
   logic [D2W-1:0]       sqd_d2_ff;
   logic signed [VW-1:0] sqd_d_ff;

   assign ad_c   = db_d_ff[VW-1] ? VW'(-db_d_ff) : VW'(db_d_ff);
   assign adsq_c = (2*LW)'(ad_c[LW-1:0]) * (2*LW)'(ad_c[LW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) sqd_valid_ff <= 1'b0;
      else       sqd_valid_ff <= db_valid_ff;
   end

   always_ff @(posedge clock) begin
      sqd_zero_ff <= db_zero_ff;
      sqd_d2_ff   <= adsq_c[FRAC_BITS +: D2W];
      sqd_d_ff    <= db_d_ff;
   end

   // knee sum and colour exponent
   logic [SW-1:0]        s_c;
   logic [D2W+23:0]      zprod_c;
   logic [D2W+7:0]       zcap_c;
   logic                 kn_valid_ff, kn_zero_ff;
   logic [SW-1:0]        kn_s_ff;
   logic [VW-1:0]        kn_z_ff;
   logic signed [VW-1:0] kn_d_ff;

   assign s_c     = SW'(sqd_d2_ff) + (SW'(softness_ff) << (FRAC_BITS - 8));
   assign zprod_c = (D2W+24)'(sqd_d2_ff) * (D2W+24)'(quality_ff);
   assign zcap_c  = (D2W+8)'(64) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) kn_valid_ff <= 1'b0;
      else       kn_valid_ff <= sqd_valid_ff;
   end

   always_ff @(posedge clock) begin
      kn_zero_ff <= sqd_zero_ff;
      kn_s_ff    <= s_c;
      kn_z_ff    <= (zprod_c[D2W+23:16] > zcap_c) ? zcap_c[VW-1:0]
                                                  : zprod_c[16 +: VW];
      kn_d_ff    <= sqd_d_ff;
   end

   // square root, one root bit per stage
   logic [VW+30:0]       wprod_c;
   logic                 sq_valid_ff [0:RB];
   logic                 sq_zero_ff  [0:RB];
   logic [XW-1:0]        sq_x_ff     [0:RB];
   logic [RW-1:0]        sq_rem_ff   [0:RB];
   logic [RB-1:0]        sq_root_ff  [0:RB];
   logic signed [VW-1:0] sq_d_ff     [0:RB];
   logic [VW-1:0]        sq_w_ff     [0:RB];

   assign wprod_c = (VW+31)'(kn_z_ff) * (VW+31)'(K_LOG2E);

   always_ff @(posedge clock) begin
      if (reset) sq_valid_ff[0] <= 1'b0;
      else       sq_valid_ff[0] <= kn_valid_ff;
   end

   always_ff @(posedge clock) begin
      sq_zero_ff[0] <= kn_zero_ff;
      sq_x_ff[0]    <= XW'(kn_s_ff) << FRAC_BITS;
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
      sq_d_ff[0]    <= kn_d_ff;
      sq_w_ff[0]    <= wprod_c[30 +: VW];
   end

   for (genvar i = 1; i <= RB; i++) begin : g_sqrt
      logic [RW-1:0] rem_n;
      logic [RW-1:0] trial;
      logic          ge;
      assign rem_n = {sq_rem_ff[i-1][RW-3:0], sq_x_ff[i-1][XW-1 -: 2]};
      assign trial = {1'b0, sq_root_ff[i-1], 2'b01};
      assign ge    = (rem_n >= trial);
      always_ff @(posedge clock) begin
         if (reset) sq_valid_ff[i] <= 1'b0;
         else       sq_valid_ff[i] <= sq_valid_ff[i-1];
      end
      always_ff @(posedge clock) begin
         sq_zero_ff[i] <= sq_zero_ff[i-1];
         sq_x_ff[i]    <= sq_x_ff[i-1] << 2;
         sq_rem_ff[i]  <= ge ? RW'(rem_n - trial) : rem_n;
         sq_root_ff[i] <= {sq_root_ff[i-1][RB-2:0], ge};
         sq_d_ff[i]    <= sq_d_ff[i-1];
         sq_w_ff[i]    <= sq_w_ff[i-1];
      end
   end

   // knee value times (ratio-1), then division by ratio
   logic signed [RB+1:0] e_c;
   logic [EB-1:0]        ep_c;
   logic [NW-1:0]        num_c;
   logic                 dv_valid_ff [0:EB];
   logic                 dv_zero_ff  [0:EB];
   logic [15:0]          dv_rem_ff   [0:EB];
   logic [EB-1:0]        dv_low_ff   [0:EB];
   logic [EB-1:0]        dv_q_ff     [0:EB];
   logic [VW-1:0]        dv_w_ff     [0:EB];

   assign e_c   = $signed({2'b00, sq_root_ff[RB]}) + sq_d_ff[RB];
   assign ep_c  = e_c[RB+1] ? '0 : e_c[EB-1:0];
   assign num_c = NW'(ep_c) * NW'(ratio_eff - RATIO_UNITY);

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else       dv_valid_ff[0] <= sq_valid_ff[RB];
   end

   always_ff @(posedge clock) begin
      dv_zero_ff[0] <= sq_zero_ff[RB];
      dv_rem_ff[0]  <= num_c[NW-1:EB];
      dv_low_ff[0]  <= num_c[EB-1:0];
      dv_q_ff[0]    <= '0;
      dv_w_ff[0]    <= sq_w_ff[RB];
   end

   for (genvar j = 1; j <= EB; j++) begin : g_div
      logic [16:0] rn;
      logic        ge;
      assign rn = {dv_rem_ff[j-1], dv_low_ff[j-1][EB-1]};
      assign ge = (rn >= {1'b0, ratio_eff});
      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[j] <= 1'b0;
         else       dv_valid_ff[j] <= dv_valid_ff[j-1];
      end
      always_ff @(posedge clock) begin
         dv_zero_ff[j] <= dv_zero_ff[j-1];
         dv_rem_ff[j]  <= ge ? 16'(rn - {1'b0, ratio_eff}) : rn[15:0];
         dv_low_ff[j]  <= dv_low_ff[j-1] << 1;
         dv_q_ff[j]    <= {dv_q_ff[j-1][EB-2:0], ge};
         dv_w_ff[j]    <= dv_w_ff[j-1];
      end
   end

   // exponent argument of the compression gain
   logic [EB+28:0] yprod_c;
   logic           ex_valid_ff, ex_zero_ff;
   logic [VW-1:0]  ex_y_ff, ex_w_ff;

   assign yprod_c = (EB+29)'(dv_q_ff[EB]) * (EB+29)'(K_EXP10);

   always_ff @(posedge clock) begin
      if (reset) ex_valid_ff <= 1'b0;
      else       ex_valid_ff <= dv_valid_ff[EB];
   end

   always_ff @(posedge clock) begin
      ex_zero_ff <= dv_zero_ff[EB];
      ex_y_ff    <= yprod_c[32 +: VW];
      ex_w_ff    <= dv_w_ff[EB];
   end

   // both exponentials in parallel
   logic [30:0] p_comp, p_bump;
   logic        pv_valid_ff [0:PL-1];
   logic        pv_zero_ff  [0:PL-1];

   cskc_pow2neg #(.FRAC_BITS(FRAC_BITS)) u_comp (
      .clock (clock),
      .v     (ex_y_ff),
      .p     (p_comp)
   );

   cskc_pow2neg #(.FRAC_BITS(FRAC_BITS)) u_bump (
      .clock (clock),
      .v     (ex_w_ff),
      .p     (p_bump)
   );

   always_ff @(posedge clock) begin
      if (reset) pv_valid_ff[0] <= 1'b0;
      else       pv_valid_ff[0] <= ex_valid_ff;
   end

   always_ff @(posedge clock) begin
      pv_zero_ff[0] <= ex_zero_ff;
   end

   for (genvar n = 1; n < PL; n++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) pv_valid_ff[n] <= 1'b0;
         else       pv_valid_ff[n] <= pv_valid_ff[n-1];
      end
      always_ff @(posedge clock) begin
         pv_zero_ff[n] <= pv_zero_ff[n-1];
      end
   end

   // colour bump, sum and saturation
   logic signed [47:0] bprod_c;
   logic signed [23:0] bump_c;
   logic signed [25:0] sum_c;
   logic signed [23:0] sat_c;
   logic               rsp_valid_ff;
   logic signed [23:0] rsp_gain_ff;

   assign bprod_c = color_ff * $signed({1'b0, p_bump});
   assign bump_c  = bprod_c[47:24];
   assign sum_c   = $signed({5'b0, p_comp[30:10]}) + bump_c;

   always_comb begin
      priority if (sum_c > $signed({{2{GAIN_MAX[23]}}, GAIN_MAX})) begin
         sat_c = $signed(GAIN_MAX);
      end else if (sum_c < $signed({{2{GAIN_MIN[23]}}, GAIN_MIN})) begin
         sat_c = $signed(GAIN_MIN);
      end else begin
         sat_c = sum_c[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= pv_valid_ff[PL-1];
   end

   always_ff @(posedge clock) begin
      rsp_gain_ff <= pv_zero_ff[PL-1] ? $signed(GAIN_ONE) : sat_c;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gain  = rsp_gain_ff;

   `ASSERT_DELAY(a_latency, clock, reset, start && !busy, LAT, rsp_valid)
   `ASSERT_IMPL(a_no_spurious, clock, reset, rsp_valid, $past(start, LAT))
   `ASSERT_DELAY(a_zero_unity, clock, reset, start && !busy && req_level == 32'd0, LAT, rsp_gain == $signed(GAIN_ONE))
endmodule
`default_nettype wire

// ===== rtl/cskc_pow2neg.sv =====
// pipelined 2^-v in q30, one fraction bit per stage
// depends on cskc_pkg
`default_nettype none
module cskc_pow2neg #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [FRAC_BITS+6:0] v,
   output logic [30:0]          p
);
   import cskc_pkg::*;

   localparam int VW = FRAC_BITS + 7;

   logic [30:0]   r_ff [0:FRAC_BITS];
   logic [VW-1:0] v_ff [0:FRAC_BITS];
   logic [30:0]   p_ff;
   logic [6:0]    ip;

   always_ff @(posedge clock) begin
      r_ff[0] <= ONE_Q30;
      v_ff[0] <= v;
   end

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
      localparam logic [29:0] COEF = pow2_coef(k);
      logic [60:0] prod;
      assign prod = 61'(r_ff[k-1]) * 61'(COEF);
      always_ff @(posedge clock) begin
         r_ff[k] <= v_ff[k-1][FRAC_BITS-k] ? prod[60:30] : r_ff[k-1];
         v_ff[k] <= v_ff[k-1];
      end
   end

   assign ip = v_ff[FRAC_BITS][VW-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      p_ff <= (ip >= 7'd31) ? 31'd0 : (r_ff[FRAC_BITS] >> ip);
   end

   assign p = p_ff;
endmodule
`default_nettype wire
